[rtl/b64d_pkg.sv]
package b64d_pkg;

	// Depth of the result-group queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_ERROR = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	// One character of encoded text
	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} in_item_t;

	// One decoded result
	typedef struct packed {
		logic [7:0] data_byte;
		kind_t      kind;
		logic       final_item;
	} out_item_t;

	// All results caused by one character (count is 1..3 when queued)
	typedef struct packed {
		logic [1:0]      count;
		logic [2:0][7:0] bytes;
		kind_t           kind;
		logic            fin;
	} group_t;

	// Class of one character
	typedef struct packed {
		logic       is_pad;
		logic       bad;
		logic [5:0] value;
	} sym_t;

	// Map a character to its sextet through the standard alphabet
	function automatic sym_t classify(input logic [7:0] c);
		sym_t s;
		s.is_pad = 1'b0;
		s.bad    = 1'b0;
		s.value  = 6'd0;
		if (c inside {[8'h41:8'h5A]}) begin
			s.value = 6'(c - 8'h41);
		end else if (c inside {[8'h61:8'h7A]}) begin
			s.value = 6'(c - 8'h61 + 8'd26);
		end else if (c inside {[8'h30:8'h39]}) begin
			s.value = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			s.value = 6'd62;
		end else if (c == 8'h2F) begin
			s.value = 6'd63;
		end else if (c == 8'h3D) begin
			s.is_pad = 1'b1;
		end else begin
			s.bad = 1'b1;
		end
		return s;
	endfunction

endpackage

[rtl/b64d_chan_if.sv]
interface b64d_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/b64d_front.sv]
module b64d_front import b64d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	b64d_chan_if.sink   text,
	input  logic        full,
	output group_t      grp,
	output logic        push
);

	logic [17:0] store_q;
	logic [1:0]  sc_q;
	logic [1:0]  pad_q;
	logic        err_q;

	logic [17:0] store_n;
	logic [1:0]  sc_n;
	logic [1:0]  pad_n;
	logic        err_n;

	logic        acc;
	logic        eot;
	sym_t        sym;
	logic        bad;
	logic        is_err;
	logic [1:0]  pad_inc;
	logic [5:0]  v;
	logic [1:0]  d;
	logic [23:0] word;
	logic [1:0]  ncnt;

	// Take a character whenever the queue has room
	assign text.ready = !full;
	assign acc        = text.valid && text.ready;
	assign eot        = text.payload.end_of_text;
	assign sym        = classify(text.payload.char_code);
	assign pad_inc    = 2'(pad_q + {1'b0, sym.is_pad});
	assign v          = sym.is_pad ? 6'd0 : sym.value;
	assign bad        = sym.bad || (sym.is_pad && sc_q < 2'd2) || (!sym.is_pad && pad_q != 2'd0);

	// Classify the character and work out the next state and results
	always_comb begin
		store_n = store_q;
		sc_n    = sc_q;
		pad_n   = pad_q;
		err_n   = err_q;
		is_err  = 1'b0;
		word    = 24'd0;
		ncnt    = 2'd0;
		d       = 2'd0;
		if (err_q) begin
			if (eot) begin
				err_n = 1'b0;
			end
		end else begin
			if (!(pad_q != 2'd0 && sc_q == 2'd0)) begin
				if (bad) begin
					is_err  = 1'b1;
					store_n = 18'd0;
					sc_n    = 2'd0;
					pad_n   = 2'd0;
					err_n   = !eot;
				end else if (sc_q == 2'd3) begin
					word    = {store_q, v};
					ncnt    = 2'(2'd3 - pad_inc);
					store_n = 18'd0;
					sc_n    = 2'd0;
					pad_n   = pad_inc;
				end else begin
					store_n = {store_q[11:0], v};
					sc_n    = 2'(sc_q + 2'd1);
					pad_n   = pad_inc;
				end
			end
			// Flush a partial group at the end of the text
			if (eot && !is_err) begin
				if (ncnt == 2'd0 && sc_n >= 2'd2 && sc_n >= pad_n) begin
					d = 2'(sc_n - pad_n);
					if (d >= 2'd2) begin
						ncnt = 2'(d - 2'd1);
						word = (sc_n == 2'd2) ? {store_n[11:0], 12'd0} : {store_n, 6'd0};
					end
				end
				store_n = 18'd0;
				sc_n    = 2'd0;
				pad_n   = 2'd0;
				err_n   = 1'b0;
			end
		end
	end

	// Pack the results of this character
	always_comb begin
		grp.count    = 2'd0;
		grp.bytes[0] = word[23:16];
		grp.bytes[1] = word[15:8];
		grp.bytes[2] = word[7:0];
		grp.kind     = KIND_DATA;
		grp.fin      = eot;
		if (is_err) begin
			grp.count = 2'd1;
			grp.bytes = '0;
			grp.kind  = KIND_ERROR;
			grp.fin   = 1'b1;
		end else if (ncnt != 2'd0) begin
			grp.count = ncnt;
		end else if (eot && !err_q) begin
			grp.count = 2'd1;
			grp.bytes = '0;
			grp.kind  = KIND_END;
			grp.fin   = 1'b1;
		end
	end

	assign push = acc && (grp.count != 2'd0);

	// Advance the decoder state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= 18'd0;
			sc_q    <= 2'd0;
			pad_q   <= 2'd0;
			err_q   <= 1'b0;
		end else if (acc) begin
			store_q <= store_n;
			sc_q    <= sc_n;
			pad_q   <= pad_n;
			err_q   <= err_n;
		end
	end

endmodule

[rtl/b64d_queue.sv]
module b64d_queue import b64d_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  group_t wdata,
	input  logic   pop,
	output group_t rdata,
	output logic   empty,
	output logic   full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	group_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign empty = (cnt_q == CNT_W'(0));
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign rdata = mem_q[rd_q];

	// Store a group at the write pointer
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// Advance pointers and hold the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : PTR_W'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : PTR_W'(rd_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

endmodule

[rtl/b64d_back.sv]
module b64d_back import b64d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	b64d_chan_if.source decoded,
	input  group_t      head,
	input  logic        empty,
	output logic        pop
);

	logic [1:0] idx_q;
	logic       last;

	// Walk through the bytes of the head group, one per transfer
	assign last                      = (idx_q == 2'(head.count - 2'd1));
	assign decoded.valid             = !empty;
	assign decoded.payload.data_byte = head.bytes[idx_q];
	assign decoded.payload.kind      = head.kind;
	assign decoded.payload.final_item = head.fin && last;
	assign pop                       = decoded.valid && decoded.ready && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (decoded.valid && decoded.ready) begin
			idx_q <= last ? 2'd0 : 2'(idx_q + 2'd1);
		end
	end

endmodule

[rtl/base64_stream_decoder_core.sv]
// Channel  | Dir | Payload                                | Transfer
// text     | in  | char_code[7:0], end_of_text            | valid & ready
// decoded  | out | data_byte[7:0], kind[1:0], final_item  | valid & ready
//
// Text takes one character per cycle and stalls only when the result-group queue
// is full; results are registered in the queue and show on decoded from there.
// Each result is one transfer, so a full group of four characters gives three.
// Reset clears the decoder state and the queue at once; there is no clearing pass.
// The two sides stall on their own through the queue (depth QUEUE_DEPTH_P).
module base64_stream_decoder_core import b64d_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	b64d_chan_if.sink   text,
	b64d_chan_if.source decoded
);

	group_t grp;
	group_t head;
	logic   push;
	logic   pop;
	logic   empty;
	logic   full;

	// Classify characters and build result groups
	b64d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.full   (full),
		.grp    (grp),
		.push   (push)
	);

	// Hold groups between the two sides
	b64d_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (grp),
		.pop    (pop),
		.rdata  (head),
		.empty  (empty),
		.full   (full)
	);

	// Send results out one at a time
	b64d_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.decoded (decoded),
		.head    (head),
		.empty   (empty),
		.pop     (pop)
	);

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("result queue overflow");

	a_status_final: assert property (@(posedge clk) disable iff (!arst_n)
		decoded.valid && decoded.payload.kind != KIND_DATA |->
			decoded.payload.final_item && decoded.payload.data_byte == 8'd0)
		else $error("error or end result not final or carries data");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty && head.count != 2'd0)
		else $error("pop of empty or zero-count group");
`endif

endmodule
